// ===== rtl/ahd_pkg.sv =====
// ----------------------------------------------------------------------------
// ahd_pkg
// Shared types, constants and the byte-wide crc update for the ax.25 hdlc
// deframer.
// ----------------------------------------------------------------------------
package ahd_pkg;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // register word index, taken from paddr[2]
  localparam logic REG_MIN_COUNT = 1'b0;
  localparam logic REG_MAX_BITS  = 1'b1;

  localparam logic [15:0] MIN_COUNT_RESET = 16'd17;
  localparam logic [15:0] MAX_BITS_RESET  = 16'd2640;

  localparam logic [7:0]  FLAG_PATTERN = 8'h7E;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h8408;
  localparam logic [15:0] CRC_RESIDUE  = 16'hF0B8;
  localparam logic [2:0]  STUFF_RUN    = 3'd5;
  localparam logic [15:0] DELAY_BITS   = 16'd7;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_END     = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_t;

  typedef struct packed {
    logic [15:0] min_count;
    logic [15:0] max_bits;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data_byte;
    logic       crc_ok;
  } res_t;

  // reflected crc-16/x.25, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/ahd_cfg.sv =====
// ----------------------------------------------------------------------------
// ahd_cfg
// APB register file: frame length limits.
// ----------------------------------------------------------------------------
module ahd_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ahd_pkg::APB_AW-1:0] paddr,
  input  logic [ahd_pkg::APB_DW-1:0] pwdata,
  output logic [ahd_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output ahd_pkg::cfg_t              cfg
);
  import ahd_pkg::*;

  logic        wr_en;
  logic        reg_sel;
  logic [15:0] min_count;
  logic [15:0] max_bits;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_count <= MIN_COUNT_RESET;
      max_bits  <= MAX_BITS_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MIN_COUNT: min_count <= pwdata[15:0];
        REG_MAX_BITS:  max_bits  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_COUNT: prdata = {16'h0000, min_count};
      REG_MAX_BITS:  prdata = {16'h0000, max_bits};
      default:       prdata = '0;
    endcase
  end

  assign cfg.min_count = min_count;
  assign cfg.max_bits  = max_bits;

endmodule

// ===== rtl/ahd_core.sv =====
// ----------------------------------------------------------------------------
// ahd_core
// Per-bit deframing state: flag hunt, delay line, unstuffer, byte packer, crc.
// ----------------------------------------------------------------------------
module ahd_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          in_bit,
  input  ahd_pkg::cfg_t cfg,
  output ahd_pkg::res_t res
);
  import ahd_pkg::*;

  logic        in_frame,    in_frame_next;
  logic [7:0]  flag_window, flag_window_next;
  logic [15:0] raw_count,   raw_count_next;
  logic [6:0]  delay_line,  delay_line_next;
  logic [2:0]  ones_run,    ones_run_next;
  logic [7:0]  byte_shift,  byte_shift_next;
  logic [2:0]  bit_index,   bit_index_next;
  logic [15:0] crc_reg,     crc_reg_next;

  logic [7:0]  win;
  logic        leaving;
  logic        stored;
  logic [7:0]  full_byte;

  always_comb begin
    win              = {in_bit, flag_window[7:1]};
    leaving          = delay_line[0];
    stored           = 1'b0;
    full_byte        = byte_shift;
    in_frame_next    = in_frame;
    flag_window_next = win;
    raw_count_next   = raw_count;
    delay_line_next  = delay_line;
    ones_run_next    = ones_run;
    byte_shift_next  = byte_shift;
    bit_index_next   = bit_index;
    crc_reg_next     = crc_reg;
    res              = '0;
    res.kind         = KIND_DATA;

    if (!in_frame) begin
      if (win == FLAG_PATTERN) begin
        in_frame_next    = 1'b1;
        flag_window_next = '0;
        raw_count_next   = '0;
        delay_line_next  = '0;
        ones_run_next    = '0;
        byte_shift_next  = '0;
        bit_index_next   = '0;
        crc_reg_next     = CRC_INIT;
      end
    end else if (raw_count > cfg.max_bits) begin
      in_frame_next = 1'b0;
      res.valid     = 1'b1;
      res.kind      = KIND_DISCARD;
    end else if (win == FLAG_PATTERN) begin
      in_frame_next = 1'b0;
      res.valid     = 1'b1;
      if (raw_count > cfg.min_count) begin
        res.kind   = KIND_END;
        res.crc_ok = (crc_reg == CRC_RESIDUE);
      end else begin
        res.kind = KIND_DISCARD;
      end
    end else begin
      delay_line_next = {in_bit, delay_line[6:1]};
      if (raw_count != COUNT_MAX) begin
        raw_count_next = raw_count + 16'd1;
      end
      if (raw_count >= DELAY_BITS) begin
        // bits after five ones are stuffing and get dropped
        if (ones_run < STUFF_RUN) begin
          stored                     = 1'b1;
          full_byte[bit_index]       = byte_shift[bit_index] | leaving;
          byte_shift_next            = full_byte;
          bit_index_next             = bit_index + 3'd1;
        end
        if (leaving) begin
          if (ones_run < STUFF_RUN) begin
            ones_run_next = ones_run + 3'd1;
          end
        end else begin
          ones_run_next = '0;
        end
        if (stored && (bit_index == 3'd7)) begin
          crc_reg_next    = crc_byte(crc_reg, full_byte);
          byte_shift_next = '0;
          bit_index_next  = '0;
          res.valid       = 1'b1;
          res.kind        = KIND_DATA;
          res.data_byte   = full_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      flag_window <= '0;
      raw_count   <= '0;
      delay_line  <= '0;
      ones_run    <= '0;
      byte_shift  <= '0;
      bit_index   <= '0;
      crc_reg     <= CRC_INIT;
    end else if (step) begin
      in_frame    <= in_frame_next;
      flag_window <= flag_window_next;
      raw_count   <= raw_count_next;
      delay_line  <= delay_line_next;
      ones_run    <= ones_run_next;
      byte_shift  <= byte_shift_next;
      bit_index   <= bit_index_next;
      crc_reg     <= crc_reg_next;
    end
  end

endmodule

// ===== rtl/ax25_hdlc_deframer.sv =====
// ----------------------------------------------------------------------------
// ax25_hdlc_deframer
// AX.25 HDLC receive deframer with bit unstuffing and CRC-16/X.25 check.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_bit) takes one line bit per transfer,
// in line order. Output channel (out_valid/out_ready) returns at most one
// result per input bit: kind 0 is a data byte (first bit in bit 0), kind 1
// marks a frame that ended at a flag with crc_ok set on residue 0xF0B8,
// kind 2 marks a frame discarded as too short or too long.
// A result shows on the output in the cycle after the bit that caused it
// is transferred. Throughput: one bit per cycle while no held result stalls
// the input; the deframer state and the byte-wide crc update are done in a
// single pass from the state registers into the output register.
// A held output result stalls the input only while out_ready is low; when the
// receiver takes the result the next bit is transferred in the same cycle.
// Reset (rst, synchronous) returns to flag hunting, empties the output and
// loads min_count 17 and max_bits 2640. The APB port writes the limits at
// byte addresses 0 and 4; write them only while no frame is in progress.
// ----------------------------------------------------------------------------
module ax25_hdlc_deframer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ahd_pkg::APB_AW-1:0] paddr,
  input  logic [ahd_pkg::APB_DW-1:0] pwdata,
  output logic [ahd_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_bit,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 kind,
  output logic [7:0]                 data_byte,
  output logic                       crc_ok
);
  import ahd_pkg::*;

  cfg_t       cfg;
  res_t       core_res;
  logic       step;
  kind_t      out_kind;
  logic [7:0] out_byte;
  logic       out_ok;

  ahd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  ahd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .in_bit (in_bit),
    .cfg    (cfg),
    .res    (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && core_res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (step && core_res.valid) begin
      out_kind <= core_res.kind;
      out_byte <= core_res.data_byte;
      out_ok   <= core_res.crc_ok;
    end
  end

  assign kind      = out_kind;
  assign data_byte = out_byte;
  assign crc_ok    = out_ok;

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    (step && core_res.valid) |=> out_valid)
    else $error("result from accepted bit not presented");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_byte_only_on_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind != KIND_DATA)) |-> (out_byte == 8'h00))
    else $error("nonzero data byte on frame status result");

  a_crc_ok_only_on_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ok) |-> (out_kind == KIND_END))
    else $error("crc_ok set outside frame end result");

endmodule

// ===== tb/ax25_hdlc_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ax25_hdlc_deframer_tb
// Self-checking bench for the ax.25 hdlc receive deframer.
// Line bits are sent one per transfer. A bit-level model in the scoreboard
// class tracks flag hunting, the delay line, unstuffing, byte packing and
// the crc-16/x.25 register, and predicts every data byte, frame end and
// discard. Results are checked in order, field by field. The limit registers
// are rewritten over the apb port between phases, only once the deframer is
// hunting again and all results have come back. Each phase mixes
// well-formed frames, broken frames and line noise.
// ----------------------------------------------------------------------------
module ax25_hdlc_deframer_tb;

  import ahd_pkg::*;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       ok;
  } deframe_res_t;

  class deframe_scoreboard;
    logic [15:0]  min_count;
    logic [15:0]  max_bits;
    bit           in_frame;
    logic [7:0]   window;
    logic [15:0]  raw_count;
    logic [6:0]   delay_bits;
    logic [2:0]   ones_run;
    logic [7:0]   byte_acc;
    logic [3:0]   bit_idx;
    logic [15:0]  crc;
    deframe_res_t due_results[$];
    int           errors;
    int           n_bytes;
    int           n_good;
    int           n_bad;
    int           n_discard;

    function new();
      min_count = MIN_COUNT_RESET;
      max_bits  = MAX_BITS_RESET;
      in_frame  = 1'b0;
      window    = '0;
      restart_frame();
    endfunction

    function void restart_frame();
      raw_count  = '0;
      delay_bits = '0;
      ones_run   = '0;
      byte_acc   = '0;
      bit_idx    = '0;
      crc        = CRC_INIT;
    endfunction

    // reflected crc-16/x.25, one input bit at a time
    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int k = 0; k < 8; k++) begin
        fb = c[0] ^ b[k];
        c  = c >> 1;
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void await_result(kind_t k, logic [7:0] d, logic ok);
      deframe_res_t r;
      r.kind = k;
      r.data = d;
      r.ok   = ok;
      due_results.push_back(r);
    endfunction

    function void note_bit(logic b);
      logic leaving;
      bit   past_delay;
      bit   kept;
      window = {b, window[7:1]};
      if (!in_frame) begin
        if (window == FLAG_PATTERN) begin
          in_frame = 1'b1;
          window   = '0;
          restart_frame();
        end
        return;
      end
      // overlong check wins over the flag
      if (raw_count > max_bits) begin
        in_frame = 1'b0;
        await_result(KIND_DISCARD, 8'h00, 1'b0);
        return;
      end
      if (window == FLAG_PATTERN) begin
        in_frame = 1'b0;
        if (raw_count > min_count) await_result(KIND_END, 8'h00, crc == CRC_RESIDUE);
        else await_result(KIND_DISCARD, 8'h00, 1'b0);
        return;
      end
      leaving    = delay_bits[0];
      past_delay = raw_count >= DELAY_BITS;
      delay_bits = {b, delay_bits[6:1]};
      if (raw_count != COUNT_MAX) raw_count = raw_count + 16'd1;
      if (!past_delay) return;
      // a bit after five ones is a stuffed bit and is dropped
      kept = ones_run < STUFF_RUN;
      if (kept) begin
        byte_acc[bit_idx[2:0]] = leaving;
        bit_idx = bit_idx + 4'd1;
      end
      if (!leaving) ones_run = '0;
      else if (ones_run < STUFF_RUN) ones_run = ones_run + 3'd1;
      if (kept && bit_idx == 4'd8) begin
        crc = crc_step(crc, byte_acc);
        await_result(KIND_DATA, byte_acc, 1'b0);
        byte_acc = '0;
        bit_idx  = '0;
      end
    endfunction

    task report(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [1:0] k, logic [7:0] d, logic ok);
      deframe_res_t r;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h", k, d));
        return;
      end
      r = due_results.pop_front();
      if (k !== r.kind) report($sformatf("kind %0d, want %0d", k, r.kind));
      if (d !== r.data) report($sformatf("data_byte %02h, want %02h", d, r.data));
      if (ok !== r.ok) report($sformatf("crc_ok %0b, want %0b", ok, r.ok));
      case (r.kind)
        KIND_DATA: n_bytes++;
        KIND_END:  if (r.ok) n_good++; else n_bad++;
        default:   n_discard++;
      endcase
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_bit = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        kind;
  logic [7:0]        data_byte;
  logic              crc_ok;

  deframe_scoreboard sb;
  bit                tx_gaps = 1'b1;
  bit                rx_gaps = 1'b1;
  int                tx_ones = 0;
  int                bits_sent = 0;

  ax25_hdlc_deframer u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_bit    (in_bit),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .data_byte (data_byte),
    .crc_ok    (crc_ok)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stall before each transfer while rx_gaps is set
  initial begin : receiver
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rx_gaps ? $urandom_range(0, 18) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) sb.check_result(kind, data_byte, crc_ok);
  end

  task automatic send_bit(input logic b);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bit   <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_bit(b);
    bits_sent++;
  endtask

  task automatic send_flag();
    for (int i = 0; i < 8; i++) send_bit(FLAG_PATTERN[i]);
    tx_ones = 0;
  endtask

  task automatic send_stuffed_byte(input logic [7:0] b);
    for (int i = 0; i < 8; i++) begin
      send_bit(b[i]);
      tx_ones = b[i] ? tx_ones + 1 : 0;
      if (tx_ones == 5) begin
        send_bit(1'b0);
        tx_ones = 0;
      end
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return FLAG_PATTERN;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input logic [7:0] payload[$], input bit corrupt);
    logic [15:0] fcs;
    fcs = CRC_INIT;
    if (sb.in_frame) send_flag();
    send_flag();
    foreach (payload[i]) begin
      fcs = deframe_scoreboard::crc_step(fcs, payload[i]);
      send_stuffed_byte(payload[i]);
    end
    fcs = ~fcs;
    if (corrupt) fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
    send_stuffed_byte(fcs[7:0]);
    send_stuffed_byte(fcs[15:8]);
    send_flag();
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_bit(1'($urandom_range(0, 1)));
  endtask

  task automatic send_random_chunk();
    logic [7:0] payload[$];
    tx_gaps = $urandom_range(0, 3) != 0;
    rx_gaps = $urandom_range(0, 3) != 0;
    payload = {};
    repeat ($urandom_range(0, 5)) payload.push_back(pick_byte());
    case ($urandom_range(0, 9))
      0, 1: send_noise($urandom_range(4, 40));
      2: begin
        // frame cut short by an abort run of ones or by raw noise
        send_flag();
        foreach (payload[i]) send_stuffed_byte(payload[i]);
        if ($urandom_range(0, 1)) repeat ($urandom_range(7, 12)) send_bit(1'b1);
        else send_noise($urandom_range(1, 24));
      end
      default: send_frame(payload, $urandom_range(0, 3) == 0);
    endcase
  endtask

  task automatic close_open_frame();
    int k;
    k = 0;
    while (sb.in_frame) begin
      send_bit(FLAG_PATTERN[k]);
      k = (k + 1) % 8;
    end
    tx_ones = 0;
  endtask

  // stop sending and wait for every pending result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi);
    close_open_frame();
    drain();
    apb_write({REG_MIN_COUNT, 2'b00}, lo);
    apb_write({REG_MAX_BITS, 2'b00}, hi);
    sb.min_count = lo;
    sb.max_bits  = hi;
  endtask

  task automatic random_phase(input int n_bits);
    int stop;
    stop = bits_sent + n_bits;
    while (bits_sent < stop) send_random_chunk();
  endtask

  initial begin : stimulus
    logic [7:0] payload[$];
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset limits: noise while hunting, good and bad fcs, stuffing-heavy bytes
    send_noise(4);
    payload = '{8'h00, 8'hFF, 8'h7E};
    send_frame(payload, 1'b0);
    send_frame(payload, 1'b1);
    // flag right after flag: too short
    send_flag();
    send_flag();
    // trailing partial byte is dropped
    send_flag();
    send_stuffed_byte(8'hA5);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    send_flag();
    // run of ones past the stuffing limit
    send_flag();
    repeat (13) send_bit(1'b1);
    send_bit(1'b0);
    send_stuffed_byte(8'h55);
    send_flag();
    random_phase(30);

    set_limits(16'd0, 16'd8);
    random_phase(30);

    // bytes already out, then the frame runs too long
    set_limits(16'hFFFF, 16'd40);
    random_phase(30);

    // no length limit: a long run of ones ends only at a flag
    set_limits(16'd200, 16'hFFFF);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_flag();
    send_stuffed_byte(8'h3C);
    repeat (60) send_bit(1'b1);
    send_flag();
    drain();
    random_phase(30);

    set_limits(16'($urandom_range(0, 120)), 16'($urandom_range(8, 400)));
    random_phase(30);

    close_open_frame();
    drain();
    repeat (10) @(posedge clk);
    $display("sent %0d line bits over five limit settings", bits_sent);
    $display("results: %0d bytes, %0d good fcs, %0d bad fcs, %0d discarded",
             sb.n_bytes, sb.n_good, sb.n_bad, sb.n_discard);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== ax25_hdlc_deframer.f =====
rtl/ahd_pkg.sv
rtl/ahd_cfg.sv
rtl/ahd_core.sv
rtl/ax25_hdlc_deframer.sv
tb/ax25_hdlc_deframer_tb.sv
